// ===== hdl/nearest_neighbor_search_macros.svh =====
// Assertion shorthands, clocked on clock and held off during reset
`ifndef NEAREST_NEIGHBOR_SEARCH_MACROS_SVH
`define NEAREST_NEIGHBOR_SEARCH_MACROS_SVH

// same-cycle implication
`define NNS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nearest_neighbor_search: check failed");

// next-cycle implication
`define NNS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nearest_neighbor_search: check failed");

`endif

// ===== hdl/nns_pkg.sv =====
`default_nettype none
package nns_pkg;

   localparam int IDX_W              = 6;
   localparam int COORD_W            = 16;
   localparam int POINT_W            = 3 * COORD_W;
   localparam int COUNT_W            = 7;
   localparam int DIST_W             = 36;
   localparam int SQ_W               = 32;
   localparam int SUM_W              = 34;
   localparam int CSR_IDX_W          = 1;
   localparam int MAX_POINTS_DEFAULT = 64;

   localparam logic [DIST_W-1:0]    LIMIT_RESET    = '1;
   localparam logic                 KIND_WRITE     = 1'b0;
   localparam logic                 KIND_QUERY     = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LIMIT  = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic capture;
      logic fetch;
      logic load;
      logic issue;
      logic finish;
   } nns_cmd_type;

   typedef struct packed {
      logic in_range;
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
      logic rsp_free;
   } nns_status_type;

endpackage
`default_nettype wire

// ===== hdl/nns_req_if.sv =====
`default_nettype none
interface nns_req_if;
   import nns_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [IDX_W-1:0]          point_index;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, kind, point_index, coord_x, coord_y, coord_z,
                   input ready);
   modport sink   (input valid, kind, point_index, coord_x, coord_y, coord_z,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/nns_rsp_if.sv =====
`default_nettype none
interface nns_rsp_if;
   import nns_pkg::*;

   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  query_index;
   logic [IDX_W-1:0]  nearest_index;
   logic              found;
   logic [DIST_W-1:0] nearest_dist_sq;

   modport source (output valid, query_index, nearest_index, found, nearest_dist_sq,
                   input ready);
   modport sink   (input valid, query_index, nearest_index, found, nearest_dist_sq,
                   output ready);
endinterface
`default_nettype wire

// ===== hdl/nearest_neighbor_search.sv =====
// channel | dir | handshake   | carries
// req_ch  | in  | valid/ready | kind, point_index, coord_x/y/z
// rsp_ch  | out | valid/ready | query_index, nearest_index, found, nearest_dist_sq
// csr     | in  | csr_we      | csr_index, csr_wdata (no read-back)
//
// A write is stored on accept. A query steps through fetch, load, scan and drain
// before its result is registered and the next item taken; the scan is skipped
// when n is zero, n being point_count capped at MAX_POINTS: the single memory
// read port gives one stored point per cycle to a three-stage distance pipeline.
// Reset clears configuration and control; the point store is not cleared.
// A result waits in the output register; the next item is taken meanwhile,
// but a following query holds in its last step until that result is taken.
`default_nettype none
module nearest_neighbor_search #(
   parameter int MAX_POINTS = nns_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   nns_req_if.sink                            req_ch,
   nns_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [nns_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nns_pkg::DIST_W-1:0]    csr_wdata
);
   import nns_pkg::*;

   nns_cmd_type    cmd;
   nns_status_type status;
   logic           req_ready;

   assign req_ch.ready = req_ready;

   nns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nns_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_point_index     (req_ch.point_index),
      .req_coord_x         (req_ch.coord_x),
      .req_coord_y         (req_ch.coord_y),
      .req_coord_z         (req_ch.coord_z),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_query_index     (rsp_ch.query_index),
      .rsp_nearest_index   (rsp_ch.nearest_index),
      .rsp_found           (rsp_ch.found),
      .rsp_nearest_dist_sq (rsp_ch.nearest_dist_sq)
   );

endmodule
`default_nettype wire

// ===== hdl/nns_ctrl.sv =====
`default_nettype none
module nns_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_kind,
   output logic                         req_ready,
   input  wire nns_pkg::nns_status_type status,
   output nns_pkg::nns_cmd_type         cmd
);
   import nns_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (!status.in_range || status.count_zero) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/nns_datapath.sv =====
`default_nettype none
module nns_datapath #(
   parameter int MAX_POINTS = nns_pkg::MAX_POINTS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire nns_pkg::nns_cmd_type             cmd,
   output nns_pkg::nns_status_type               status,
   input  wire logic [nns_pkg::IDX_W-1:0]        req_point_index,
   input  wire logic signed [nns_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [nns_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [nns_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic                             csr_we,
   input  wire logic [nns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [nns_pkg::DIST_W-1:0]       csr_wdata,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [nns_pkg::IDX_W-1:0]             rsp_query_index,
   output logic [nns_pkg::IDX_W-1:0]             rsp_nearest_index,
   output logic                                  rsp_found,
   output logic [nns_pkg::DIST_W-1:0]            rsp_nearest_dist_sq
);
   import nns_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [POINT_W-1:0] mem [MAX_POINTS];

   logic [COUNT_W-1:0] point_count_ff;
   logic [DIST_W-1:0]  limit_ff;
   logic [IDX_W-1:0]   qidx_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      n_lim;
   logic               wr_in_range;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;

   logic [POINT_W-1:0] rd_data_ff;
   logic [POINT_W-1:0] qpoint_ff;

   logic               s1_valid_ff;
   logic               s1_skip_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic               s2_valid_ff;
   logic               s2_skip_ff;
   logic [AW-1:0]      s2_idx_ff;
   logic [SQ_W-1:0]    sq_x_ff;
   logic [SQ_W-1:0]    sq_y_ff;
   logic [SQ_W-1:0]    sq_z_ff;
   logic               s3_valid_ff;
   logic               s3_skip_ff;
   logic [AW-1:0]      s3_idx_ff;
   logic [SUM_W-1:0]   sum_ff;

   logic               found_ff;
   logic [SUM_W-1:0]   best_d_ff;
   logic [AW-1:0]      best_i_ff;
   logic               better;

   logic signed [COORD_W:0]     dx, dy, dz;
   logic signed [2*COORD_W+1:0] px2, py2, pz2;

   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_query_ff;
   logic [IDX_W-1:0]   rsp_nearest_ff;
   logic               rsp_found_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;

   always_comb begin
      if (int'(point_count_ff) > MAX_POINTS) begin
         n_lim = CW'(MAX_POINTS);
      end else begin
         n_lim = CW'(point_count_ff);
      end
   end

   assign wr_in_range       = int'(req_point_index) < MAX_POINTS;
   assign status.in_range   = int'(qidx_ff) < MAX_POINTS;
   assign status.count_zero = (n_lim == '0);
   assign status.scan_last  = (cnt_ff == n_lim - CW'(1));
   assign status.pipe_busy  = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         limit_ff       <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POINT_COUNT: begin
               point_count_ff <= csr_wdata[COUNT_W-1:0];
            end
            CSR_DIST_LIMIT: begin
               limit_ff <= csr_wdata;
            end
            default: begin
               limit_ff <= limit_ff;
            end
         endcase
      end
   end

   assign rd_addr = cmd.fetch ? AW'(qidx_ff) : cnt_ff[AW-1:0];
   assign rd_en   = (cmd.fetch && status.in_range) || cmd.issue;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_range) begin
         mem[AW'(req_point_index)] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qidx_ff <= req_point_index;
      end
      if (cmd.load) begin
         qpoint_ff <= rd_data_ff;
         cnt_ff    <= '0;
      end else if (cmd.issue) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   // difference and square per axis
   always_comb begin
      dx  = $signed({qpoint_ff[3*COORD_W-1], qpoint_ff[3*COORD_W-1:2*COORD_W]})
          - $signed({rd_data_ff[3*COORD_W-1], rd_data_ff[3*COORD_W-1:2*COORD_W]});
      dy  = $signed({qpoint_ff[2*COORD_W-1], qpoint_ff[2*COORD_W-1:COORD_W]})
          - $signed({rd_data_ff[2*COORD_W-1], rd_data_ff[2*COORD_W-1:COORD_W]});
      dz  = $signed({qpoint_ff[COORD_W-1], qpoint_ff[COORD_W-1:0]})
          - $signed({rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]});
      px2 = dx * dx;
      py2 = dy * dy;
      pz2 = dz * dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= cnt_ff[AW-1:0];
      s1_skip_ff <= (int'(cnt_ff) == int'(qidx_ff));
      s2_idx_ff  <= s1_idx_ff;
      s2_skip_ff <= s1_skip_ff;
      sq_x_ff    <= px2[SQ_W-1:0];
      sq_y_ff    <= py2[SQ_W-1:0];
      sq_z_ff    <= pz2[SQ_W-1:0];
      s3_idx_ff  <= s2_idx_ff;
      s3_skip_ff <= s2_skip_ff;
      sum_ff     <= SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   end

   assign better = s3_valid_ff && !s3_skip_ff && (DIST_W'(sum_ff) < limit_ff)
                   && (!found_ff || (sum_ff < best_d_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         best_d_ff <= '0;
         best_i_ff <= '0;
      end else if (better) begin
         best_d_ff <= sum_ff;
         best_i_ff <= s3_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_query_ff   <= qidx_ff;
         rsp_nearest_ff <= IDX_W'(best_i_ff);
         rsp_found_ff   <= found_ff;
         rsp_dist_ff    <= DIST_W'(best_d_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_query_index     = rsp_query_ff;
   assign rsp_nearest_index   = rsp_nearest_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;

endmodule
`default_nettype wire

// ===== hdl/nns_checker.sv =====
`default_nettype none
`include "nearest_neighbor_search_macros.svh"
module nns_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_kind,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [nns_pkg::IDX_W-1:0]  rsp_query_index,
   input wire logic [nns_pkg::IDX_W-1:0]  rsp_nearest_index,
   input wire logic                       rsp_found,
   input wire logic [nns_pkg::DIST_W-1:0] rsp_nearest_dist_sq
);
   import nns_pkg::*;

   `NNS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `NNS_ASSERT_NOW(a_not_found_zero, rsp_valid && !rsp_found, rsp_nearest_index == '0 && rsp_nearest_dist_sq == '0)
   `NNS_ASSERT_NOW(a_not_self, rsp_valid && rsp_found, rsp_nearest_index != rsp_query_index)
   `NNS_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_kind == KIND_QUERY, !req_ready)

endmodule

bind nearest_neighbor_search nns_checker u_nns_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .req_kind            (req_ch.kind),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_query_index     (rsp_ch.query_index),
   .rsp_nearest_index   (rsp_ch.nearest_index),
   .rsp_found           (rsp_ch.found),
   .rsp_nearest_dist_sq (rsp_ch.nearest_dist_sq)
);
`default_nettype wire
